// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values, round functions and controller types.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_PAD,
        t_ST_LEN,
        t_ST_COMP,
        t_ST_FIN,
        t_ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_byte;      // write in_byte at fill pointer
        logic       wr_pad;       // write padding byte at pad pointer
        logic [5:0] pad_addr;
        logic [7:0] pad_data;
        logic       comp_start;   // load working variables
        logic       comp_round;   // run one round
        logic       comp_finish;  // add working variables into chain value
        logic       emit_shift;   // rotate chain value for output
        logic       reinit;       // load initial hash values
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[r];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

endpackage

// ----- hdl/sha256_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, working variables and chaining value.
// ----------------------------------------------------------------------------
module sha256_dp (
    input  logic              i_clk,
    input  sha256_pkg::t_cmd  i_cmd,
    input  logic [5:0]        i_fill,
    input  logic [5:0]        i_round,
    input  logic [7:0]        i_byte,
    output logic [31:0]       o_word
);

    // Buffer held as 16 big-endian words; byte writes go in place.
    logic [31:0] r_buf [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_h   [8];

    logic [31:0] wr_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [5:0]  waddr;
    logic [7:0]  wdata;
    logic        wen;

    assign wen   = i_cmd.wr_byte | i_cmd.wr_pad;
    assign waddr = i_cmd.wr_byte ? i_fill : i_cmd.pad_addr;
    assign wdata = i_cmd.wr_byte ? i_byte : i_cmd.pad_data;

    always_comb begin
        if (i_round < 6'd16) begin
            wr_word = r_w[0];
        end else begin
            wr_word = r_w[0] + sha256_pkg::sig0(r_w[1]) + sha256_pkg::sig1(r_w[14])
                    + r_w[9];
        end
        t1 = r_v[7] + sha256_pkg::bsig1(r_v[4]) + sha256_pkg::ch(r_v[4], r_v[5], r_v[6])
           + sha256_pkg::round_k(i_round) + wr_word;
        t2 = sha256_pkg::bsig0(r_v[0]) + sha256_pkg::maj(r_v[0], r_v[1], r_v[2]);
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            case (waddr[1:0])
                2'd0:    r_buf[waddr[5:2]][31:24] <= wdata;
                2'd1:    r_buf[waddr[5:2]][23:16] <= wdata;
                2'd2:    r_buf[waddr[5:2]][15:8]  <= wdata;
                default: r_buf[waddr[5:2]][7:0]   <= wdata;
            endcase
        end

        if (i_cmd.comp_start) begin
            r_w <= r_buf;
            r_v <= r_h;
        end else if (i_cmd.comp_round) begin
            // The schedule window slides by one word each round.
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j + 1];
            end
            r_w[15] <= wr_word;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end

        if (i_cmd.reinit) begin
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= sha256_pkg::init_h(3'(j));
            end
        end else if (i_cmd.comp_finish) begin
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= r_h[j] + r_v[j];
            end
        end else if (i_cmd.emit_shift) begin
            for (int j = 0; j < 7; j++) begin
                r_h[j] <= r_h[j + 1];
            end
            r_h[7] <= r_h[0];
        end
    end

    assign o_word = r_h[0];

endmodule

// ----- hdl/sha256_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_word_index,
    output logic              o_last,
    output logic [5:0]        o_fill,
    output logic [5:0]        o_round,
    output sha256_pkg::t_cmd  o_cmd
);

    sha256_pkg::t_state r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_round, n_round;
    logic [63:0] r_bits, n_bits;
    logic        r_final, n_final;   // compression belongs to a finalize
    logic        r_two, n_two;       // a second padding block follows
    logic [5:0]  r_pad, n_pad;
    logic [2:0]  r_idx, n_idx;
    logic        r_run;              // working variables loaded, rounds running
    logic        n_run;

    logic acc;
    logic done_round;

    assign acc        = i_valid && o_ready;
    assign done_round = r_run && (r_round == 6'd63);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_round = r_round;
        n_bits  = r_bits;
        n_final = r_final;
        n_two   = r_two;
        n_pad   = r_pad;
        n_idx   = r_idx;
        n_run   = r_run;
        case (r_state)
            sha256_pkg::t_ST_IDLE: begin
                if (acc) begin
                    if (!i_operation) begin
                        n_fill = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            n_state = sha256_pkg::t_ST_COMP;
                            n_final = 1'b0;
                            n_bits  = r_bits + 64'd512;
                        end
                    end else begin
                        n_bits  = r_bits + {55'd0, r_fill, 3'd0};
                        n_two   = (r_fill >= 6'd56);
                        n_pad   = r_fill;
                        n_final = 1'b1;
                        n_state = sha256_pkg::t_ST_PAD;
                    end
                end
            end
            sha256_pkg::t_ST_PAD: begin
                // Writes 0x80 then zeros up to byte 55, or 63 for two blocks.
                n_pad = r_pad + 6'd1;
                if ((r_two && r_pad == 6'd63) || (!r_two && r_pad == 6'd55)) begin
                    n_state = r_two ? sha256_pkg::t_ST_COMP : sha256_pkg::t_ST_LEN;
                    n_pad   = r_two ? 6'd0 : 6'd56;
                end
            end
            sha256_pkg::t_ST_LEN: begin
                n_pad = r_pad + 6'd1;
                if (r_pad == 6'd63) begin
                    n_state = sha256_pkg::t_ST_COMP;
                end
            end
            sha256_pkg::t_ST_COMP: begin
                if (!r_run) begin
                    n_run   = 1'b1;
                    n_round = 6'd0;
                end else begin
                    n_round = r_round + 6'd1;
                    if (done_round) begin
                        n_run   = 1'b0;
                        n_state = sha256_pkg::t_ST_FIN;
                    end
                end
            end
            sha256_pkg::t_ST_FIN: begin
                // The last round has landed; the chain value takes the sum now.
                if (!r_final) begin
                    n_state = sha256_pkg::t_ST_IDLE;
                end else if (r_two) begin
                    n_two   = 1'b0;
                    n_pad   = 6'd0;
                    n_state = sha256_pkg::t_ST_PAD;
                end else begin
                    n_idx   = 3'd0;
                    n_state = sha256_pkg::t_ST_EMIT;
                end
            end
            sha256_pkg::t_ST_EMIT: begin
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = sha256_pkg::t_ST_IDLE;
                        n_fill  = 6'd0;
                        n_bits  = 64'd0;
                        n_final = 1'b0;
                    end
                end
            end
            default: n_state = sha256_pkg::t_ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd          = '0;
        o_ready        = (r_state == sha256_pkg::t_ST_IDLE);
        o_valid        = (r_state == sha256_pkg::t_ST_EMIT);
        o_cmd.wr_byte  = acc && !i_operation;
        o_cmd.pad_addr = r_pad;
        case (r_state)
            sha256_pkg::t_ST_PAD: begin
                o_cmd.wr_pad   = 1'b1;
                o_cmd.pad_data = (r_final && r_pad == r_fill && !(r_two == 1'b0 && r_pad < r_fill))
                               ? 8'h80 : 8'h00;
            end
            sha256_pkg::t_ST_LEN: begin
                o_cmd.wr_pad   = 1'b1;
                o_cmd.pad_data = r_bits[8 * (63 - r_pad) +: 8];
            end
            sha256_pkg::t_ST_COMP: begin
                o_cmd.comp_start  = !r_run;
                o_cmd.comp_round  = r_run;
            end
            sha256_pkg::t_ST_FIN: begin
                o_cmd.comp_finish = 1'b1;
            end
            sha256_pkg::t_ST_EMIT: begin
                o_cmd.emit_shift = i_ready;
                o_cmd.reinit     = i_ready && (r_idx == 3'd7);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::t_ST_IDLE;
            r_fill  <= '0;
            r_round <= '0;
            r_bits  <= '0;
            r_final <= 1'b0;
            r_two   <= 1'b0;
            r_pad   <= '0;
            r_idx   <= '0;
            r_run   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_bits  <= n_bits;
            r_final <= n_final;
            r_two   <= n_two;
            r_pad   <= n_pad;
            r_idx   <= n_idx;
            r_run   <= n_run;
        end
    end

    assign o_fill       = r_fill;
    assign o_round      = r_round;
    assign o_word_index = r_idx;
    assign o_last       = (r_idx == 3'd7);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while emitting");
    a_full_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_operation && r_fill == 6'd63) |=> (r_state == sha256_pkg::t_ST_COMP))
        else $error("full buffer not compressed");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_idx)))
        else $error("digest word dropped");

endmodule

// ----- hdl/sha256_stream_hasher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and emits the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// Usage: each input item carries i_operation and i_data_byte. Operation 0
// absorbs one byte. On the 64th byte of a block the block runs the
// compression: it loads the working variables, runs 64 rounds at one per
// cycle and folds the result into the chaining value, with ready low
// throughout. Operation 1 finalizes: the padding is written one byte per
// cycle into the buffer (in two passes when 56 or more bytes are buffered),
// each padded block is compressed in the same way, and then the eight digest
// words leave on the output channel, word index 0 first, last set on word 7.
// The compression round is a single unit shared by every block. When the
// receiver stalls, the current word is held and nothing else advances.
// After the eighth word the chaining value, count and buffer pointer return
// to their initial values. Reset is synchronous and active low and brings
// the block to idle; the initial hash values are loaded in the first cycle
// after reset, during which ready stays low.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last
);

    sha256_pkg::t_cmd ctrl_cmd;
    sha256_pkg::t_cmd dp_cmd;
    logic [5:0] fill;
    logic [5:0] round;
    logic       ctl_ready;
    logic       r_boot;   // holds off input until the chain value is loaded

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot <= 1'b1;
        end else begin
            r_boot <= 1'b0;
        end
    end

    // Load the initial hash values during the cycle after reset.
    always_comb begin
        dp_cmd = ctrl_cmd;
        if (r_boot) begin
            dp_cmd.reinit = 1'b1;
        end
    end

    assign o_ready = ctl_ready && !r_boot;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid && !r_boot),
        .o_ready      (ctl_ready),
        .i_operation  (i_operation),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_index (o_word_index),
        .o_last       (o_last),
        .o_fill       (fill),
        .o_round      (round),
        .o_cmd        (ctrl_cmd)
    );

    sha256_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (dp_cmd),
        .i_fill  (fill),
        .i_round (round),
        .i_byte  (i_data_byte),
        .o_word  (o_digest_word)
    );

endmodule

// ----- verif/tb_sha256_stream_hasher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams and finalize commands into the hasher and checks every
// digest word against a SHA-256 predictor kept inside the scoreboard.
// ----------------------------------------------------------------------------

// Scoreboard: it keeps a private copy of the hash state, computes the digest
// whenever a finalize item is accepted, and queues the eight expected words.
class sha256_digest_board;
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  byte_fill;
    logic [63:0] bit_total;
    logic [31:0] digest_q [$];
    logic [2:0]  index_q [$];
    logic        last_q [$];
    int          error_count;
    int          words_checked;
    int          digests_seen;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function new();
        error_count = 0;
        words_checked = 0;
        digests_seen = 0;
        restart();
    endfunction

    function void restart();
        foreach (hash_state[j]) hash_state[j] = H_START[j];
        foreach (msg_block[j]) msg_block[j] = 8'h00;
        byte_fill = 6'd0;
        bit_total = 64'd0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void run_rounds();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 16; j < 64; j++)
            w[j] = w[j-16] + w[j-7]
                 + (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3))
                 + (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[r] + w[r];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    // Notes one accepted input item and, on finalize, queues the digest.
    function void note_input(logic op, logic [7:0] data);
        int pos;
        if (op == 1'b0) begin
            msg_block[byte_fill] = data;
            if (byte_fill == 6'd63) begin
                run_rounds();
                bit_total += 64'd512;
            end
            byte_fill = byte_fill + 6'd1;
            return;
        end
        bit_total += {55'd0, byte_fill, 3'd0};
        msg_block[byte_fill] = 8'h80;
        pos = byte_fill + 1;
        if (pos > 56) begin
            for (int j = pos; j < 64; j++) msg_block[j] = 8'h00;
            run_rounds();
            pos = 0;
        end
        for (int j = pos; j < 56; j++) msg_block[j] = 8'h00;
        for (int j = 0; j < 8; j++) msg_block[63 - j] = bit_total[8*j +: 8];
        run_rounds();
        for (int j = 0; j < 8; j++) begin
            digest_q.push_back(hash_state[j]);
            index_q.push_back(j[2:0]);
            last_q.push_back(j == 7);
        end
        digests_seen++;
        restart();
    endfunction

    // Checks one accepted digest word against the oldest expectation.
    function void check_word(logic [31:0] word, logic [2:0] idx, logic lst);
        logic [31:0] exp_word;
        logic [2:0]  exp_idx;
        logic        exp_last;
        if (digest_q.size() == 0) begin
            $error("digest word %08h arrived with nothing expected", word);
            error_count++;
            return;
        end
        exp_word = digest_q.pop_front();
        exp_idx = index_q.pop_front();
        exp_last = last_q.pop_front();
        words_checked++;
        if (word !== exp_word) begin
            $error("digest_word: expected %08h, got %08h", exp_word, word);
            error_count++;
        end
        if (idx !== exp_idx) begin
            $error("word_index: expected %0d, got %0d", exp_idx, idx);
            error_count++;
        end
        if (lst !== exp_last) begin
            $error("last: expected %0b, got %0b", exp_last, lst);
            error_count++;
        end
    endfunction
endclass

module tb_sha256_stream_hasher_core;

    localparam logic OP_ABSORB   = 1'b0;
    localparam logic OP_FINALIZE = 1'b1;
    localparam int   DRAIN_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_operation;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last;

    sha256_digest_board board;
    // Set while the receiver must hold off for a long stretch.
    logic        hold_off;
    int          items_sent;

    sha256_stream_hasher_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last       (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Both sides of the handshake are observed at the rising edge. Inputs are
    // updated with nonblocking assignments at that same edge, so the monitor
    // always sees the values that were present during the preceding cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            board.note_input(i_operation, i_data_byte);
        if (i_rst_n && o_valid && i_ready)
            board.check_word(o_digest_word, o_word_index, o_last);
    end

    // Offers one item and waits for its handshake. Valid is dropped only when
    // a gap follows, so back-to-back items keep it high without a second
    // update in the same step; wait_drained drops it when the sender pauses.
    task automatic send_item(input logic op, input logic [7:0] data, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Random gap with a fair share of back-to-back items.
    function automatic int pick_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_message(input int len, input bit busy);
        for (int j = 0; j < len; j++)
            send_item(OP_ABSORB, $urandom_range(0, 255), busy ? 0 : pick_gap());
        send_item(OP_FINALIZE, $urandom_range(0, 255), busy ? 0 : pick_gap());
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.digest_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: for every word it draws a random stall, and during
    // long stretches it drops ready altogether while the hold-off is set.
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall > 0 || hold_off) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // The long hold-off is counted in cycles by this process while the sender
    // keeps offering items, so the output backs up and the input stalls.
    initial begin
        hold_off = 1'b0;
        @(posedge i_clk iff items_sent >= 30);
        hold_off = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        board       = new();
        items_sent  = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_ABSORB;
        i_data_byte <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, a repeated finalize, extreme bytes.
        send_item(OP_FINALIZE, 8'h00, 0);
        send_item(OP_FINALIZE, 8'hff, 0);
        send_item(OP_ABSORB, 8'h00, 0);
        send_item(OP_ABSORB, 8'hff, 0);
        send_item(OP_ABSORB, 8'h55, 1);
        send_item(OP_ABSORB, 8'haa, 0);
        send_item(OP_FINALIZE, 8'h00, 0);

        // The sender pauses here until every expected word has come.
        wait_drained();

        // 56 buffered bytes leave no room for the length, so the padding
        // spills into a second block.
        send_message(56, 1'b1);

        // Random short messages, offered while the receiver holds off.
        for (int m = 0; m < 8; m++)
            send_message($urandom_range(0, 6), 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.digest_q.size() != 0) begin
            $error("%0d digest words never arrived", board.digest_q.size());
            board.error_count++;
        end
        $display("Covered %0d items, %0d digests and %0d digest words checked.",
                 items_sent, board.digests_seen, board.words_checked);
        if (board.error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d words still expected.", board.digest_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sha256_stream_hasher_core.f -----
hdl/sha256_pkg.sv
hdl/sha256_dp.sv
hdl/sha256_ctrl.sv
hdl/sha256_stream_hasher_core.sv
verif/tb_sha256_stream_hasher_core.sv
